>>> rtl/core/clrp_pkg.sv
// Shared types, constants and lookup functions of the cockpit link receive parser.
package clrp_pkg;

    // Frame and queue sizing
    localparam int FRAME_LENGTH = 19;
    localparam int QUEUE_DEPTH  = 4;
    localparam int IDX_W        = 5;

    // Handshake phases
    localparam logic [2:0] PHASE_HUNT   = 3'd0;
    localparam logic [2:0] PHASE_REPLY1 = 3'd1;
    localparam logic [2:0] PHASE_LAST   = 3'd5;
    localparam logic [2:0] PHASE_DONE   = 3'd6;

    // Link bytes
    localparam logic [7:0] BYTE_SYNC   = 8'h11;
    localparam logic [7:0] CMD_PHASE1  = 8'h12;
    localparam logic [7:0] CMD_PHASE2  = 8'h22;
    localparam logic [7:0] CMD_PHASE3  = 8'h21;
    localparam logic [7:0] CMD_PHASE4  = 8'h23;
    localparam logic [7:0] CMD_PHASE5  = 8'h53;
    localparam logic [7:0] FRAME_HDR_A = 8'h40;
    localparam logic [7:0] FRAME_HDR_B = 8'h41;

    // Frame byte positions that carry telemetry
    localparam logic [IDX_W-1:0] POS_POWER   = 5'd5;
    localparam logic [IDX_W-1:0] POS_CADENCE = 5'd6;
    localparam logic [IDX_W-1:0] POS_SPEED   = 5'd7;
    localparam logic [IDX_W-1:0] POS_DIST_LO = 5'd8;
    localparam logic [IDX_W-1:0] POS_DIST_HI = 5'd9;
    localparam logic [IDX_W-1:0] POS_HEART   = 5'd14;
    localparam logic [IDX_W-1:0] POS_GEAR    = 5'd16;

    // Scale factors of the decoded fields
    localparam logic [10:0] POWER_SCALE = 11'd5;
    localparam logic [22:0] DIST_SCALE  = 23'd100;

    // Request passed from the front part to the decode part
    typedef struct packed {
        logic [2:0] phase;
        logic       advanced;
        logic       stalled;
        logic [7:0] address;
        logic       fvalid;
        logic [7:0] b_power;
        logic [7:0] b_cadence;
        logic [7:0] b_speed;
        logic [7:0] b_dist_lo;
        logic [7:0] b_dist_hi;
        logic [7:0] b_heart;
        logic [7:0] b_gear;
    } t_req;

    // Command byte expected at the start of each reply
    function automatic logic [7:0] cmd_of_phase(input logic [2:0] phase);
        logic [7:0] cmd;
        unique case (phase)
            3'd1:    cmd = CMD_PHASE1;
            3'd2:    cmd = CMD_PHASE2;
            3'd3:    cmd = CMD_PHASE3;
            3'd4:    cmd = CMD_PHASE4;
            3'd5:    cmd = CMD_PHASE5;
            default: cmd = 8'h00;
        endcase
        return cmd;
    endfunction

    // Reply length of each phase
    function automatic logic [2:0] len_of_phase(input logic [2:0] phase);
        logic [2:0] len;
        unique case (phase)
            3'd1:    len = 3'd2;
            3'd2:    len = 3'd3;
            3'd3:    len = 3'd3;
            3'd4:    len = 3'd4;
            3'd5:    len = 3'd3;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/core/clrp_front.sv
// Front part: tracks the handshake, hunts and collects telemetry frames, issues decode requests.
module clrp_front #(
    parameter int FRAME_LENGTH = clrp_pkg::FRAME_LENGTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_mode,
    input  logic [7:0]     i_rx_byte,
    output clrp_pkg::t_req o_req
);

    localparam int                       IW      = clrp_pkg::IDX_W;
    localparam logic [IW:0]              LEN_END = (IW+1)'(FRAME_LENGTH);

    logic [2:0]    r_phase,    n_phase;
    logic [7:0]    r_address,  n_address;
    logic          r_await,    n_await;
    logic          r_stall,    n_stall;
    logic [2:0]    r_count,    n_count;
    logic [7:0]    r_prev,     n_prev;
    logic          r_active,   n_active;
    logic [IW-1:0] r_index,    n_index;
    logic [7:0]    r_b_power,  n_b_power;
    logic [7:0]    r_b_cad,    n_b_cad;
    logic [7:0]    r_b_speed,  n_b_speed;
    logic [7:0]    r_b_dlo,    n_b_dlo;
    logic [7:0]    r_b_dhi,    n_b_dhi;
    logic [7:0]    r_b_heart,  n_b_heart;
    logic [7:0]    r_b_gear,   n_b_gear;
    logic          advanced;
    logic          fvalid;
    logic [2:0]    count_inc;

    assign count_inc = r_count + 3'd1;

    // Classify the byte and work out the next parser state
    always_comb begin
        n_phase   = r_phase;
        n_address = r_address;
        n_await   = r_await;
        n_stall   = r_stall;
        n_count   = r_count;
        n_prev    = r_prev;
        n_active  = r_active;
        n_index   = r_index;
        n_b_power = r_b_power;
        n_b_cad   = r_b_cad;
        n_b_speed = r_b_speed;
        n_b_dlo   = r_b_dlo;
        n_b_dhi   = r_b_dhi;
        n_b_heart = r_b_heart;
        n_b_gear  = r_b_gear;
        advanced  = 1'b0;
        fvalid    = 1'b0;
        if (i_mode) begin
            // restart the handshake on connect
            n_phase   = clrp_pkg::PHASE_HUNT;
            n_address = 8'h00;
            n_await   = 1'b0;
            n_stall   = 1'b0;
            n_count   = 3'd0;
            n_prev    = 8'h00;
            n_active  = 1'b0;
            n_index   = '0;
        end else if (r_phase == clrp_pkg::PHASE_HUNT) begin
            if (r_await) begin
                n_address = i_rx_byte;
                n_await   = 1'b0;
                n_phase   = clrp_pkg::PHASE_REPLY1;
                n_count   = 3'd0;
                advanced  = 1'b1;
            end else if (i_rx_byte == clrp_pkg::BYTE_SYNC) begin
                n_await = 1'b1;
            end
        end else if (r_phase <= clrp_pkg::PHASE_LAST) begin
            if (!r_stall) begin
                if ((r_count == 3'd0 && i_rx_byte != clrp_pkg::cmd_of_phase(r_phase)) ||
                    (r_count == 3'd1 && i_rx_byte != r_address)) begin
                    n_stall = 1'b1;
                end else if (count_inc >= clrp_pkg::len_of_phase(r_phase)) begin
                    n_count  = 3'd0;
                    n_phase  = r_phase + 3'd1;
                    n_prev   = 8'h00;
                    advanced = 1'b1;
                end else begin
                    n_count = count_inc;
                end
            end
        end else if (r_phase == clrp_pkg::PHASE_DONE) begin
            if (r_active) begin
                // capture the telemetry bytes by position
                if (r_index == clrp_pkg::POS_POWER)   n_b_power = i_rx_byte;
                if (r_index == clrp_pkg::POS_CADENCE) n_b_cad   = i_rx_byte;
                if (r_index == clrp_pkg::POS_SPEED)   n_b_speed = i_rx_byte;
                if (r_index == clrp_pkg::POS_DIST_LO) n_b_dlo   = i_rx_byte;
                if (r_index == clrp_pkg::POS_DIST_HI) n_b_dhi   = i_rx_byte;
                if (r_index == clrp_pkg::POS_HEART)   n_b_heart = i_rx_byte;
                if (r_index == clrp_pkg::POS_GEAR)    n_b_gear  = i_rx_byte;
                if ({1'b0, r_index} + (IW+1)'(1) >= LEN_END) begin
                    n_active = 1'b0;
                    n_index  = '0;
                    n_prev   = 8'h00;
                    fvalid   = 1'b1;
                end else begin
                    n_index = r_index + IW'(1);
                end
            end else if ((r_prev == clrp_pkg::FRAME_HDR_A || r_prev == clrp_pkg::FRAME_HDR_B) &&
                         i_rx_byte == r_address) begin
                n_active = 1'b1;
                n_index  = IW'(2);
                n_prev   = i_rx_byte;
            end else begin
                n_prev = i_rx_byte;
            end
        end
    end

    // Form the request for the decode part
    always_comb begin
        o_req.phase     = n_phase;
        o_req.advanced  = advanced;
        o_req.stalled   = n_stall;
        o_req.address   = n_address;
        o_req.fvalid    = fvalid;
        o_req.b_power   = n_b_power;
        o_req.b_cadence = n_b_cad;
        o_req.b_speed   = n_b_speed;
        o_req.b_dist_lo = n_b_dlo;
        o_req.b_dist_hi = n_b_dhi;
        o_req.b_heart   = n_b_heart;
        o_req.b_gear    = n_b_gear;
    end

    // Advance the control state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= clrp_pkg::PHASE_HUNT;
            r_address <= 8'h00;
            r_await   <= 1'b0;
            r_stall   <= 1'b0;
            r_count   <= 3'd0;
            r_prev    <= 8'h00;
            r_active  <= 1'b0;
            r_index   <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_address <= n_address;
            r_await   <= n_await;
            r_stall   <= n_stall;
            r_count   <= n_count;
            r_prev    <= n_prev;
            r_active  <= n_active;
            r_index   <= n_index;
        end
    end

    // Hold the captured frame bytes
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_b_power <= n_b_power;
            r_b_cad   <= n_b_cad;
            r_b_speed <= n_b_speed;
            r_b_dlo   <= n_b_dlo;
            r_b_dhi   <= n_b_dhi;
            r_b_heart <= n_b_heart;
            r_b_gear  <= n_b_gear;
        end
    end

endmodule

>>> rtl/core/clrp_queue.sv
// Small register queue between the front part and the decode part.
module clrp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = clrp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    // Store the request at the write pointer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> rtl/core/clrp_back.sv
// Decode part: scales the power and distance fields and holds the result until it is taken.
module clrp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  clrp_pkg::t_req i_head,
    output logic           o_head_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [2:0]     o_handshake_phase,
    output logic           o_phase_advanced,
    output logic           o_handshake_stalled,
    output logic [7:0]     o_cockpit_address,
    output logic           o_frame_valid,
    output logic [10:0]    o_power_watts,
    output logic [7:0]     o_cadence_rpm,
    output logic [7:0]     o_speed_raw,
    output logic [22:0]    o_distance_m,
    output logic [7:0]     o_heart_rate,
    output logic [7:0]     o_gear_raw
);

    logic        r_valid;
    logic [10:0] n_power;
    logic [22:0] n_dist;
    logic        load;

    assign load       = i_head_valid && (!r_valid || i_pop);
    assign o_head_pop = load;
    assign o_empty    = !r_valid;

    // Scale power and distance
    always_comb begin
        n_power = 11'd0;
        n_dist  = 23'd0;
        if (i_head.fvalid) begin
            if (i_head.b_cadence != 8'h00) begin
                n_power = {3'b000, i_head.b_power} * clrp_pkg::POWER_SCALE;
            end
            n_dist = {7'b0, i_head.b_dist_hi, i_head.b_dist_lo} * clrp_pkg::DIST_SCALE;
        end
    end

    // Track whether a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (load) begin
            o_handshake_phase   <= i_head.phase;
            o_phase_advanced    <= i_head.advanced;
            o_handshake_stalled <= i_head.stalled;
            o_cockpit_address   <= i_head.address;
            o_frame_valid       <= i_head.fvalid;
            o_power_watts       <= n_power;
            o_cadence_rpm       <= i_head.fvalid ? i_head.b_cadence : 8'h00;
            o_speed_raw         <= i_head.fvalid ? i_head.b_speed : 8'h00;
            o_distance_m        <= n_dist;
            o_heart_rate        <= i_head.fvalid ? i_head.b_heart : 8'h00;
            o_gear_raw          <= i_head.fvalid ? i_head.b_gear : 8'h00;
        end
    end

endmodule

>>> rtl/core/cockpit_link_receive_parser.sv
// Top level of the cockpit link receive parser: front part, request queue, decode part.
// Throughput: one byte per cycle while full is low; every accepted byte yields exactly one result.
// Path: an accepted byte is written to the request queue, then loaded into the result
//   register once that is empty or being popped (queue write, then result load).
// full rises only when the request queue holds QUEUE_DEPTH waiting requests.
// Reset: synchronous, active low; clears parser, queue control and result valid, no clearing pass.
module cockpit_link_receive_parser #(
    parameter int FRAME_LENGTH = clrp_pkg::FRAME_LENGTH,
    parameter int QUEUE_DEPTH  = clrp_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_mode,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_handshake_phase,
    output logic        o_phase_advanced,
    output logic        o_handshake_stalled,
    output logic [7:0]  o_cockpit_address,
    output logic        o_frame_valid,
    output logic [10:0] o_power_watts,
    output logic [7:0]  o_cadence_rpm,
    output logic [7:0]  o_speed_raw,
    output logic [22:0] o_distance_m,
    output logic [7:0]  o_heart_rate,
    output logic [7:0]  o_gear_raw
);

    localparam int REQ_W = $bits(clrp_pkg::t_req);

    clrp_pkg::t_req front_req;
    clrp_pkg::t_req head_req;
    logic [REQ_W-1:0] head_bits;
    logic             accept;
    logic             q_empty;
    logic             head_pop;

    assign accept   = push && !full;
    assign head_req = clrp_pkg::t_req'(head_bits);

    clrp_front #(
        .FRAME_LENGTH(FRAME_LENGTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_mode    (i_mode),
        .i_rx_byte (i_rx_byte),
        .o_req     (front_req)
    );

    clrp_queue #(
        .WIDTH(REQ_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_wdata (front_req),
        .o_full  (full),
        .i_rd    (head_pop),
        .o_empty (q_empty),
        .o_rdata (head_bits)
    );

    clrp_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_head_valid        (!q_empty),
        .i_head              (head_req),
        .o_head_pop          (head_pop),
        .o_empty             (empty),
        .i_pop               (pop),
        .o_handshake_phase   (o_handshake_phase),
        .o_phase_advanced    (o_phase_advanced),
        .o_handshake_stalled (o_handshake_stalled),
        .o_cockpit_address   (o_cockpit_address),
        .o_frame_valid       (o_frame_valid),
        .o_power_watts       (o_power_watts),
        .o_cadence_rpm       (o_cadence_rpm),
        .o_speed_raw         (o_speed_raw),
        .o_distance_m        (o_distance_m),
        .o_heart_rate        (o_heart_rate),
        .o_gear_raw          (o_gear_raw)
    );

    // A completed frame only appears once the handshake is done
    a_frame_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_valid) |-> (o_handshake_phase == clrp_pkg::PHASE_DONE))
        else $error("frame result outside the completed handshake");

    // Power is reported only with nonzero cadence
    a_power_cadence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_power_watts != 11'd0) |-> (o_cadence_rpm != 8'h00))
        else $error("power reported with zero cadence");

    // A byte never both finishes a reply and a frame
    a_single_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_phase_advanced && o_frame_valid))
        else $error("reply and frame completed by one byte");

    // A request queued into an idle path reaches the result register next cycle
    a_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_empty && empty) |=> !empty)
        else $error("queued request not forwarded");

endmodule

>>> verif/cockpit_link_receive_parser_tb.sv
// Self-checking testbench of the cockpit link receive parser.
`timescale 1ns / 1ps

module cockpit_link_receive_parser_tb;

    // Input item kinds
    localparam logic LINK_BYTE    = 1'b0;
    localparam logic LINK_CONNECT = 1'b1;

    localparam int unsigned STREAM_TARGET  = 1900;
    localparam int unsigned HOLD_OFF_AFTER = 400;
    localparam int unsigned HOLD_OFF_LEN   = 60;
    localparam int unsigned CALM_LEN       = 40;
    localparam int unsigned DIRECTED_COUNT = 29;

    // One result of the parser, field by field
    typedef struct packed {
        logic [2:0]  phase;
        logic        advanced;
        logic        stalled;
        logic [7:0]  address;
        logic        fvalid;
        logic [10:0] power;
        logic [7:0]  cadence;
        logic [7:0]  speed;
        logic [22:0] distance;
        logic [7:0]  heart;
        logic [7:0]  gear;
    } t_parser_report;

    // Directed row: the byte sent and, where typed, the result it must give
    typedef struct packed {
        logic       mode;
        logic [7:0] rx;
        logic       typed;
        logic [2:0] phase;
        logic       advanced;
        logic       stalled;
        logic [7:0] address;
    } t_directed_row;

    localparam t_directed_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{LINK_CONNECT, 8'h00, 1'b1, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, clrp_pkg::BYTE_SYNC, 1'b1, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, 8'hFF, 1'b1, clrp_pkg::PHASE_REPLY1, 1'b1, 1'b0, 8'hFF},
        '{LINK_BYTE, clrp_pkg::CMD_PHASE1, 1'b0, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, 8'h01, 1'b1, clrp_pkg::PHASE_REPLY1, 1'b0, 1'b1, 8'hFF},
        '{LINK_BYTE, clrp_pkg::CMD_PHASE1, 1'b1, clrp_pkg::PHASE_REPLY1, 1'b0, 1'b1, 8'hFF},
        '{LINK_CONNECT, 8'hFF, 1'b1, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, 8'h00, 1'b1, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, clrp_pkg::BYTE_SYNC, 1'b1, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, clrp_pkg::BYTE_SYNC, 1'b1, clrp_pkg::PHASE_REPLY1, 1'b1, 1'b0,
          clrp_pkg::BYTE_SYNC},
        '{LINK_BYTE, 8'h13, 1'b1, clrp_pkg::PHASE_REPLY1, 1'b0, 1'b1, clrp_pkg::BYTE_SYNC},
        '{LINK_CONNECT, 8'h00, 1'b1, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, clrp_pkg::BYTE_SYNC, 1'b1, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, 8'h00, 1'b1, clrp_pkg::PHASE_REPLY1, 1'b1, 1'b0, 8'h00},
        '{LINK_BYTE, clrp_pkg::CMD_PHASE1, 1'b0, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, 8'h00, 1'b0, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, clrp_pkg::CMD_PHASE2, 1'b0, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, 8'h00, 1'b0, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, 8'hAB, 1'b0, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, clrp_pkg::CMD_PHASE3, 1'b0, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, 8'h00, 1'b0, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, 8'h00, 1'b0, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, clrp_pkg::CMD_PHASE4, 1'b0, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, 8'h00, 1'b0, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, 8'hFF, 1'b0, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, 8'h55, 1'b0, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, clrp_pkg::CMD_PHASE5, 1'b0, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, 8'h00, 1'b0, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00},
        '{LINK_BYTE, 8'h7E, 1'b0, clrp_pkg::PHASE_HUNT, 1'b0, 1'b0, 8'h00}
    };

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        pop         = 1'b0;
    logic        i_mode      = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        full;
    logic        empty;
    logic [2:0]  o_handshake_phase;
    logic        o_phase_advanced;
    logic        o_handshake_stalled;
    logic [7:0]  o_cockpit_address;
    logic        o_frame_valid;
    logic [10:0] o_power_watts;
    logic [7:0]  o_cadence_rpm;
    logic [7:0]  o_speed_raw;
    logic [22:0] o_distance_m;
    logic [7:0]  o_heart_rate;
    logic [7:0]  o_gear_raw;

    // Parser state as the checker sees it
    logic [2:0]  hs_phase;
    logic [7:0]  cockpit_addr;
    logic        want_address;
    logic        hs_stalled;
    logic [2:0]  reply_pos;
    logic [7:0]  last_byte;
    logic        in_frame;
    logic [4:0]  frame_pos;
    logic [7:0]  frame_buf [32];

    // Command byte and reply length of each handshake phase
    logic [7:0]  reply_cmd [6] = '{8'h00, clrp_pkg::CMD_PHASE1, clrp_pkg::CMD_PHASE2,
                                   clrp_pkg::CMD_PHASE3, clrp_pkg::CMD_PHASE4,
                                   clrp_pkg::CMD_PHASE5};
    logic [2:0]  reply_len [6] = '{3'd0, 3'd2, 3'd3, 3'd3, 3'd4, 3'd3};

    t_parser_report pending_reports [$];
    int unsigned    error_count     = 0;
    int unsigned    results_checked = 0;
    int unsigned    stream_items    = 0;
    int unsigned    sender_calm     = 0;

    cockpit_link_receive_parser dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_mode              (i_mode),
        .i_rx_byte           (i_rx_byte),
        .empty               (empty),
        .pop                 (pop),
        .o_handshake_phase   (o_handshake_phase),
        .o_phase_advanced    (o_phase_advanced),
        .o_handshake_stalled (o_handshake_stalled),
        .o_cockpit_address   (o_cockpit_address),
        .o_frame_valid       (o_frame_valid),
        .o_power_watts       (o_power_watts),
        .o_cadence_rpm       (o_cadence_rpm),
        .o_speed_raw         (o_speed_raw),
        .o_distance_m        (o_distance_m),
        .o_heart_rate        (o_heart_rate),
        .o_gear_raw          (o_gear_raw)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Return the parser state to its power-on value
    function automatic void clear_parser_state();
        hs_phase     = clrp_pkg::PHASE_HUNT;
        cockpit_addr = 8'h00;
        want_address = 1'b0;
        hs_stalled   = 1'b0;
        reply_pos    = 3'd0;
        last_byte    = 8'h00;
        in_frame     = 1'b0;
        frame_pos    = 5'd0;
        foreach (frame_buf[k]) frame_buf[k] = 8'h00;
    endfunction

    // Advance the parser state by one input byte and return its result
    function automatic t_parser_report step_parser(input logic mode, input logic [7:0] rx);
        t_parser_report r;
        int unsigned    scaled;
        r = '0;
        if (mode == LINK_CONNECT) begin
            clear_parser_state();
        end else if (hs_phase == clrp_pkg::PHASE_HUNT) begin
            if (want_address) begin
                cockpit_addr = rx;
                want_address = 1'b0;
                hs_phase     = clrp_pkg::PHASE_REPLY1;
                reply_pos    = 3'd0;
                r.advanced   = 1'b1;
            end else if (rx == clrp_pkg::BYTE_SYNC) begin
                want_address = 1'b1;
            end
        end else if (hs_phase <= clrp_pkg::PHASE_LAST) begin
            // Check the reply prefix; a bad command or address stalls until connect
            if (!hs_stalled) begin
                if ((reply_pos == 3'd0 && rx != reply_cmd[hs_phase]) ||
                    (reply_pos == 3'd1 && rx != cockpit_addr)) begin
                    hs_stalled = 1'b1;
                end else begin
                    reply_pos = reply_pos + 3'd1;
                    if (reply_pos >= reply_len[hs_phase]) begin
                        reply_pos  = 3'd0;
                        hs_phase   = hs_phase + 3'd1;
                        last_byte  = 8'h00;
                        r.advanced = 1'b1;
                    end
                end
            end
        end else if (hs_phase == clrp_pkg::PHASE_DONE) begin
            // Collect a frame, or hunt for a header byte followed by the address
            if (in_frame) begin
                frame_buf[frame_pos] = rx;
                if (int'(frame_pos) + 1 >= clrp_pkg::FRAME_LENGTH) begin
                    in_frame  = 1'b0;
                    frame_pos = 5'd0;
                    last_byte = 8'h00;
                    r.fvalid  = 1'b1;
                end else begin
                    frame_pos = frame_pos + 5'd1;
                end
            end else if ((last_byte == clrp_pkg::FRAME_HDR_A ||
                          last_byte == clrp_pkg::FRAME_HDR_B) && rx == cockpit_addr) begin
                frame_buf[0] = last_byte;
                frame_buf[1] = rx;
                in_frame     = 1'b1;
                frame_pos    = 5'd2;
                last_byte    = rx;
            end else begin
                last_byte = rx;
            end
        end
        r.phase   = hs_phase;
        r.stalled = hs_stalled;
        r.address = cockpit_addr;
        // Decode the telemetry of a completed frame
        if (r.fvalid) begin
            r.cadence  = frame_buf[clrp_pkg::POS_CADENCE];
            scaled     = int'(frame_buf[clrp_pkg::POS_POWER]) * int'(clrp_pkg::POWER_SCALE);
            r.power    = (r.cadence == 8'h00) ? 11'd0 : scaled[10:0];
            r.speed    = frame_buf[clrp_pkg::POS_SPEED];
            scaled     = int'({frame_buf[clrp_pkg::POS_DIST_HI],
                               frame_buf[clrp_pkg::POS_DIST_LO]}) *
                         int'(clrp_pkg::DIST_SCALE);
            r.distance = scaled[22:0];
            r.heart    = frame_buf[clrp_pkg::POS_HEART];
            r.gear     = frame_buf[clrp_pkg::POS_GEAR];
        end
        return r;
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic send_byte(input logic mode, input logic [7:0] rx,
                             input bit typed = 1'b0,
                             input t_parser_report typed_report = '0);
        int unsigned    gap;
        t_parser_report predicted;
        if (sender_calm > 0) begin
            sender_calm--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 63) == 0) sender_calm = CALM_LEN;
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_mode    <= mode;
        i_rx_byte <= rx;
        do @(posedge i_clk); while (full);
        predicted = step_parser(mode, rx);
        pending_reports.push_back(typed ? typed_report : predicted);
    endtask

    function automatic logic [7:0] random_link_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] random_address();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return clrp_pkg::FRAME_HDR_A;
            3:       return clrp_pkg::FRAME_HDR_B;
            4:       return clrp_pkg::BYTE_SYNC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Connect, run the handshake and stream frames; now and then break the sequence
    task automatic run_session();
        logic [7:0]  addr;
        logic [7:0]  b;
        logic [7:0]  hdr;
        int unsigned bad_pos;
        bit          corrupt;
        bit          tail_hdr;
        int unsigned n_frames;
        send_byte(LINK_CONNECT, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) begin
            b = random_link_byte();
            send_byte(LINK_BYTE, (b == clrp_pkg::BYTE_SYNC) ? 8'h10 : b);
        end
        addr = random_address();
        send_byte(LINK_BYTE, clrp_pkg::BYTE_SYNC);
        send_byte(LINK_BYTE, addr);
        stream_items += 2;

        // Walk the five replies; a rare flipped prefix bit stalls the handshake
        tail_hdr = ($urandom_range(0, 3) == 0);
        for (int ph = 1; ph <= int'(clrp_pkg::PHASE_LAST); ph++) begin
            corrupt = ($urandom_range(0, 39) == 0);
            bad_pos = $urandom_range(0, 1);
            for (int pos = 0; pos < int'(reply_len[ph]); pos++) begin
                if (pos == 0) b = reply_cmd[ph];
                else if (pos == 1) b = addr;
                else if (ph == int'(clrp_pkg::PHASE_LAST) && tail_hdr) b = clrp_pkg::FRAME_HDR_B;
                else b = random_link_byte();
                if (corrupt && pos == int'(bad_pos)) b = b ^ (8'h01 << $urandom_range(0, 7));
                send_byte(LINK_BYTE, b);
                stream_items++;
            end
            if (corrupt) begin
                repeat ($urandom_range(1, 4)) send_byte(LINK_BYTE, random_link_byte());
                return;
            end
        end
        // A header byte that ends a reply must not open a frame
        if (tail_hdr) send_byte(LINK_BYTE, addr);

        // Stream frames with some noise between them
        n_frames = $urandom_range(1, 6);
        repeat (n_frames) begin
            repeat ($urandom_range(0, 3)) send_byte(LINK_BYTE, random_link_byte());
            hdr      = $urandom_range(0, 1) ? clrp_pkg::FRAME_HDR_A : clrp_pkg::FRAME_HDR_B;
            tail_hdr = ($urandom_range(0, 3) == 0);
            send_byte(LINK_BYTE, hdr);
            send_byte(LINK_BYTE, addr);
            for (int k = 2; k < clrp_pkg::FRAME_LENGTH; k++) begin
                b = random_link_byte();
                if (k == int'(clrp_pkg::POS_CADENCE) && $urandom_range(0, 3) == 0) b = 8'h00;
                if (k == clrp_pkg::FRAME_LENGTH - 1 && tail_hdr) b = hdr;
                if ($urandom_range(0, 299) == 0) begin
                    send_byte(LINK_CONNECT, b);
                    return;
                end
                send_byte(LINK_BYTE, b);
            end
            stream_items += clrp_pkg::FRAME_LENGTH;
            if (tail_hdr) send_byte(LINK_BYTE, addr);
        end
    endtask

    // Compare one field of a result and log a mismatch
    function automatic void check_report_field(input string name, input logic [31:0] want,
                                               input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // Check every result taken by the receiver against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_parser_report want;
        if (i_rst_n && pop && !empty) begin
            if (pending_reports.size() == 0) begin
                error_count++;
                $display("%0t ns: unexpected result, expected none actual phase %0h",
                         $time, o_handshake_phase);
            end else begin
                want = pending_reports.pop_front();
                check_report_field("handshake_phase", 32'(want.phase), 32'(o_handshake_phase));
                check_report_field("phase_advanced", 32'(want.advanced),
                                   32'(o_phase_advanced));
                check_report_field("handshake_stalled", 32'(want.stalled),
                                   32'(o_handshake_stalled));
                check_report_field("cockpit_address", 32'(want.address),
                                   32'(o_cockpit_address));
                check_report_field("frame_valid", 32'(want.fvalid), 32'(o_frame_valid));
                check_report_field("power_watts", 32'(want.power), 32'(o_power_watts));
                check_report_field("cadence_rpm", 32'(want.cadence), 32'(o_cadence_rpm));
                check_report_field("speed_raw", 32'(want.speed), 32'(o_speed_raw));
                check_report_field("distance_m", 32'(want.distance), 32'(o_distance_m));
                check_report_field("heart_rate", 32'(want.heart), 32'(o_heart_rate));
                check_report_field("gear_raw", 32'(want.gear), 32'(o_gear_raw));
            end
            results_checked++;
        end
    end

    // Receiver: random stalls, calm stretches and one long hold-off to fill the queue
    initial begin : drain_results
        int unsigned hold;
        int unsigned calm;
        bit          held_off;
        calm     = 0;
        held_off = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!held_off && results_checked >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                hold     = HOLD_OFF_LEN;
            end else if (calm > 0) begin
                calm--;
                hold = 0;
            end else begin
                hold = $urandom_range(0, 3);
                if ($urandom_range(0, 63) == 0) calm = CALM_LEN;
            end
            if (hold > 0) begin
                pop <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // Bound the run
    initial begin
        #5_000_000;
        $display("cockpit_link_receive_parser_tb NOT OK");
        $finish;
    end

    // Reset, directed rows, random sessions, drain
    initial begin : drive_stimulus
        t_parser_report typed_report;
        clear_parser_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[n]) begin
            typed_report          = '0;
            typed_report.phase    = DIRECTED_ROWS[n].phase;
            typed_report.advanced = DIRECTED_ROWS[n].advanced;
            typed_report.stalled  = DIRECTED_ROWS[n].stalled;
            typed_report.address  = DIRECTED_ROWS[n].address;
            send_byte(DIRECTED_ROWS[n].mode, DIRECTED_ROWS[n].rx,
                      DIRECTED_ROWS[n].typed, typed_report);
        end

        while (stream_items < STREAM_TARGET) run_session();
        push <= 1'b0;

        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("cockpit_link_receive_parser_tb OK");
        else
            $display("cockpit_link_receive_parser_tb NOT OK");
        $finish;
    end

endmodule

>>> cockpit_link_receive_parser.f
rtl/core/clrp_pkg.sv
rtl/core/clrp_front.sv
rtl/core/clrp_queue.sv
rtl/core/clrp_back.sv
rtl/core/cockpit_link_receive_parser.sv
verif/cockpit_link_receive_parser_tb.sv
